@@ sv/brf_pkg.sv @@
// shared types and constants for the banked register file
package brf_pkg;

    // operation codes
    localparam logic [2:0] OP_READ       = 3'd0;
    localparam logic [2:0] OP_WRITE      = 3'd1;
    localparam logic [2:0] OP_READ_USR   = 3'd2;
    localparam logic [2:0] OP_WRITE_USR  = 3'd3;
    localparam logic [2:0] OP_MODE       = 3'd4;
    localparam logic [2:0] OP_THUMB_SET  = 3'd5;
    localparam logic [2:0] OP_THUMB_CLR  = 3'd6;

    // mode codes
    localparam logic [2:0] MODE_FIQ = 3'd0;
    localparam logic [2:0] MODE_SVC = 3'd2;
    localparam logic [2:0] MODE_SYS = 3'd5;
    localparam logic [2:0] MODE_BAD = 3'd7;

    // register numbers and bank geometry
    localparam logic [3:0] REG_SP    = 4'd13;
    localparam logic [3:0] REG_LR    = 4'd14;
    localparam logic [3:0] REG_PC    = 4'd15;
    localparam logic [3:0] HIGH_BASE = 4'd8;
    localparam int         NUM_LIVE  = 16;
    localparam int         NUM_SLOTS = 6;
    localparam int         NUM_HIGH  = 5;

    // misc constants
    localparam int         PC_RESET      = 8;
    localparam logic [2:0] BYTES_THUMB   = 3'd2;
    localparam logic [2:0] BYTES_WIDE    = 3'd4;
    localparam int         DATA_WIDTH_DEF = 32;
    localparam int         PORT_WIDTH    = 32;

    // one accepted beat as seen by the register file
    typedef struct packed {
        logic       en;
        logic [2:0] op;
        logic [3:0] idx;
        logic [2:0] tgt_mode;
    } t_cmd;

    // status after the beat
    typedef struct packed {
        logic [2:0] mode;
        logic       thumb;
        logic       bad;
    } t_res;

    // bank slot of a mode: system and user share one slot
    function automatic logic [2:0] bank_slot(input logic [2:0] m);
        return (m >= MODE_SYS) ? MODE_SYS : m;
    endfunction

endpackage

@@ sv/brf_regfile.sv @@
// register state with banked swap logic and user-view access
module brf_regfile #(
    parameter int DATA_WIDTH = brf_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  brf_pkg::t_cmd         i_cmd,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata,
    output brf_pkg::t_res         o_res
);
    import brf_pkg::*;

    logic [DATA_WIDTH-1:0] r_live  [NUM_LIVE];
    logic [DATA_WIDTH-1:0] r_link  [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] r_stack [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] r_fiqh  [NUM_HIGH];
    logic [DATA_WIDTH-1:0] r_usrh  [NUM_HIGH];
    logic [2:0]            r_mode;
    logic                  r_thumb;

    logic [DATA_WIDTH-1:0] n_live  [NUM_LIVE];
    logic [DATA_WIDTH-1:0] n_link  [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] n_stack [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] n_fiqh  [NUM_HIGH];
    logic [DATA_WIDTH-1:0] n_usrh  [NUM_HIGH];
    logic [2:0]            n_mode;
    logic                  n_thumb;

    logic                  user_live;
    logic                  user_high;
    logic [2:0]            high_idx;
    logic [DATA_WIDTH-1:0] user_val;
    logic [2:0]            old_slot;
    logic [2:0]            new_slot;
    logic                  old_fiq;
    logic                  new_fiq;
    logic                  bad;
    logic [DATA_WIDTH-1:0] rdata;

    // user-view decode: which store backs the register
    assign high_idx  = i_cmd.idx[2:0];
    assign user_high = (i_cmd.idx >= HIGH_BASE) && (i_cmd.idx < REG_SP)
                     && (r_mode == MODE_FIQ);
    assign user_live = (i_cmd.idx < HIGH_BASE) || (i_cmd.idx == REG_PC)
                     || ((i_cmd.idx < REG_SP) && (r_mode != MODE_FIQ))
                     || ((i_cmd.idx >= REG_SP) && (r_mode >= MODE_SYS));

    always_comb begin
        if (user_live) begin
            user_val = r_live[i_cmd.idx];
        end else if (user_high) begin
            user_val = r_usrh[high_idx];
        end else if (i_cmd.idx == REG_SP) begin
            user_val = r_stack[MODE_SYS];
        end else begin
            user_val = r_link[MODE_SYS];
        end
    end

    assign old_slot = bank_slot(r_mode);
    assign new_slot = bank_slot(i_cmd.tgt_mode);
    assign old_fiq  = (r_mode == MODE_FIQ);
    assign new_fiq  = (i_cmd.tgt_mode == MODE_FIQ);

    // next state for one beat
    always_comb begin
        n_live  = r_live;
        n_link  = r_link;
        n_stack = r_stack;
        n_fiqh  = r_fiqh;
        n_usrh  = r_usrh;
        n_mode  = r_mode;
        n_thumb = r_thumb;
        bad     = 1'b0;
        rdata   = '0;
        if (i_cmd.en) begin
            unique case (i_cmd.op)
                OP_READ: begin
                    rdata = r_live[i_cmd.idx];
                end
                OP_WRITE: begin
                    n_live[i_cmd.idx] = i_wdata;
                end
                OP_READ_USR: begin
                    rdata = user_val;
                end
                OP_WRITE_USR: begin
                    if (user_live) begin
                        n_live[i_cmd.idx] = i_wdata;
                    end else if (user_high) begin
                        n_usrh[high_idx] = i_wdata;
                    end else if (i_cmd.idx == REG_SP) begin
                        n_stack[MODE_SYS] = i_wdata;
                    end else begin
                        n_link[MODE_SYS] = i_wdata;
                    end
                end
                OP_MODE: begin
                    if (i_cmd.tgt_mode == MODE_BAD) begin
                        bad = 1'b1;
                    end else begin
                        // r8-r12 swap on entering or leaving fiq
                        if (old_fiq != new_fiq) begin
                            for (int i = 0; i < NUM_HIGH; i++) begin
                                if (old_fiq) begin
                                    n_fiqh[i] = r_live[4'(i) + HIGH_BASE];
                                    n_live[4'(i) + HIGH_BASE] = r_usrh[i];
                                end else begin
                                    n_usrh[i] = r_live[4'(i) + HIGH_BASE];
                                    n_live[4'(i) + HIGH_BASE] = r_fiqh[i];
                                end
                            end
                        end
                        // sp/lr swap between bank slots
                        if (old_slot != new_slot) begin
                            n_stack[old_slot] = r_live[REG_SP];
                            n_link[old_slot]  = r_live[REG_LR];
                            n_live[REG_SP]    = r_stack[new_slot];
                            n_live[REG_LR]    = r_link[new_slot];
                        end
                        n_mode = i_cmd.tgt_mode;
                    end
                end
                OP_THUMB_SET: begin
                    n_thumb = 1'b1;
                end
                OP_THUMB_CLR: begin
                    n_thumb = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LIVE; i++) begin
                r_live[i] <= (i == int'(REG_PC)) ? DATA_WIDTH'(PC_RESET) : '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_link[i]  <= '0;
                r_stack[i] <= '0;
            end
            for (int i = 0; i < NUM_HIGH; i++) begin
                r_fiqh[i] <= '0;
                r_usrh[i] <= '0;
            end
            r_mode  <= MODE_SVC;
            r_thumb <= 1'b0;
        end else begin
            r_live  <= n_live;
            r_link  <= n_link;
            r_stack <= n_stack;
            r_fiqh  <= n_fiqh;
            r_usrh  <= n_usrh;
            r_mode  <= n_mode;
            r_thumb <= n_thumb;
        end
    end

    assign o_rdata     = rdata;
    assign o_res.mode  = n_mode;
    assign o_res.thumb = n_thumb;
    assign o_res.bad   = bad;

endmodule

@@ sv/banked_register_file_mode_switch.sv @@
// top level: input beat register, banked register file, result register
//
// Banked register file for a processor with seven modes. Every input beat
// (read, write, user-view read or write, mode change, thumb set or clear)
// is captured in an input register, executed against the register state
// once the result register is free or draining, and its result lands in an
// output register, from which it is offered. One beat is taken every cycle
// as long as the result side keeps up; a result that is not taken holds the
// next beat in the input register, which then holds off the input. Mode
// changes between bank slots swap r13/r14 and, on entering or leaving fiq,
// r8-r12, all in the same register update. Registers hold DATA_WIDTH bits;
// write data is truncated or zero extended to that width and read data shows
// the low 32 bits.
module banked_register_file_mode_switch #(
    parameter int DATA_WIDTH = brf_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [2:0]  i_target_mode,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_mode_now,
    output logic        o_thumb_flag,
    output logic [2:0]  o_instr_bytes,
    output logic        o_bad_mode
);
    import brf_pkg::*;

    localparam int RD_W = (DATA_WIDTH < PORT_WIDTH) ? DATA_WIDTH : PORT_WIDTH;

    logic                  r_in_valid;
    logic [2:0]            r_op;
    logic [3:0]            r_idx;
    logic [31:0]           r_wdata;
    logic [2:0]            r_target_mode;

    logic                  r_out_valid;
    logic [31:0]           r_read_data;
    logic [2:0]            r_mode_now;
    logic                  r_thumb;
    logic [2:0]            r_bytes;
    logic                  r_bad;

    logic                  advance;
    t_cmd                  cmd;
    t_res                  res;
    logic [DATA_WIDTH-1:0] rf_rdata;

    // handshake: execute when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op          <= i_op;
            r_idx         <= i_reg_index;
            r_wdata       <= i_write_data;
            r_target_mode <= i_target_mode;
        end
    end

    assign cmd.en       = advance;
    assign cmd.op       = r_op;
    assign cmd.idx      = r_idx;
    assign cmd.tgt_mode = r_target_mode;

    brf_regfile #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_wdata (DATA_WIDTH'(r_wdata)),
        .o_rdata (rf_rdata),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= 32'(rf_rdata[RD_W-1:0]);
            r_mode_now  <= res.mode;
            r_thumb     <= res.thumb;
            r_bytes     <= res.thumb ? BYTES_THUMB : BYTES_WIDE;
            r_bad       <= res.bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_mode_now    = r_mode_now;
    assign o_thumb_flag  = r_thumb;
    assign o_instr_bytes = r_bytes;
    assign o_bad_mode    = r_bad;

endmodule
